>>> src/ctf_pkg.sv
package ctf_pkg;

   localparam int CordicSteps = 16;
   localparam int StepBits = 5;

   // register map
   localparam logic [2:0] RegGyroGain = 3'd0;
   localparam logic [2:0] RegGyroOffset = 3'd1;
   localparam logic [2:0] RegAngleOffset = 3'd2;
   localparam logic [2:0] RegTimeStep = 3'd3;
   localparam logic [2:0] RegBlendWeight = 3'd4;

   // datapath commands
   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_ITER,
      CMD_MUL1,
      CMD_MUL2,
      CMD_SUM,
      CMD_MIX,
      CMD_DONE
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic [StepBits-1:0] step;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] gyro_gain;
      logic signed [24:0] gyro_offset;
      logic signed [24:0] angle_offset;
      logic [23:0] time_step;
      logic [15:0] blend_weight;
   } regs_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic [21:0] atan_entry(input logic [StepBits-1:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
         5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
         5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
         5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
         5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
         5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
         5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
         5'd21: r = 22'd2;       5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/ctf_if.sv
interface ctf_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_y;
   modport source(output valid, accel_x, accel_z, gyro_y, input ready);
   modport sink(input valid, accel_x, accel_z, gyro_y, output ready);
endinterface

interface ctf_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] tilt_angle;
   modport source(output valid, tilt_angle, input ready);
   modport sink(input valid, tilt_angle, output ready);
endinterface

>>> src/ctf_regs.sv
module ctf_regs (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output ctf_pkg::regs_type regs
);
   import ctf_pkg::*;

   regs_type regs_ff;
   logic [2:0] idx;
   logic wr;

   assign idx = csr_paddr[4:2];
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs = regs_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.gyro_gain <= 16'd500;
         regs_ff.gyro_offset <= '0;
         regs_ff.angle_offset <= '0;
         regs_ff.time_step <= 24'd83886;
         regs_ff.blend_weight <= 16'd64881;
      end else if (wr) begin
         priority case (idx)
            RegGyroGain: regs_ff.gyro_gain <= csr_pwdata[15:0];
            RegGyroOffset: regs_ff.gyro_offset <= csr_pwdata[24:0];
            RegAngleOffset: regs_ff.angle_offset <= csr_pwdata[24:0];
            RegTimeStep: regs_ff.time_step <= csr_pwdata[23:0];
            RegBlendWeight: regs_ff.blend_weight <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      priority case (idx)
         RegGyroGain: csr_prdata = {16'd0, regs_ff.gyro_gain};
         RegGyroOffset: csr_prdata = {{7{regs_ff.gyro_offset[24]}}, regs_ff.gyro_offset};
         RegAngleOffset: csr_prdata = {{7{regs_ff.angle_offset[24]}}, regs_ff.angle_offset};
         RegTimeStep: csr_prdata = {8'd0, regs_ff.time_step};
         RegBlendWeight: csr_prdata = {16'd0, regs_ff.blend_weight};
         default: csr_prdata = '0;
      endcase
   end
endmodule

>>> src/ctf_ctrl.sv
module ctf_ctrl (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input logic out_ready,
   output ctf_pkg::ctrl_type ctrl
);
   import ctf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ITER, S_MUL1, S_MUL2, S_SUM, S_MIX, S_OUT
   } state_type;

   state_type state_ff;
   logic [StepBits-1:0] step_ff;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

   always_comb begin
      ctrl.step = step_ff;
      unique case (state_ff)
         S_IDLE: ctrl.cmd = (in_valid) ? CMD_LOAD : CMD_IDLE;
         S_ITER: ctrl.cmd = CMD_ITER;
         S_MUL1: ctrl.cmd = CMD_MUL1;
         S_MUL2: ctrl.cmd = CMD_MUL2;
         S_SUM: ctrl.cmd = CMD_SUM;
         S_MIX: ctrl.cmd = CMD_MIX;
         S_OUT: ctrl.cmd = (out_ready) ? CMD_DONE : CMD_IDLE;
         default: ctrl.cmd = CMD_IDLE;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               state_ff <= S_ITER;
               step_ff <= '0;
            end
            S_ITER: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepBits'(CordicSteps - 1)) state_ff <= S_MUL1;
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_SUM;
            S_SUM: state_ff <= S_MIX;
            S_MIX: state_ff <= S_OUT;
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset) !(in_ready && out_valid))
      else $error("accepting while holding a result");
   a_iter_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER) |-> (step_ff < StepBits'(CordicSteps)))
      else $error("cordic step overrun");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped");
endmodule

>>> src/ctf_datapath.sv
module ctf_datapath (
   input logic clock,
   input logic reset,
   input ctf_pkg::ctrl_type ctrl,
   input ctf_pkg::regs_type regs,
   input logic signed [15:0] accel_x,
   input logic signed [15:0] accel_z,
   input logic signed [15:0] gyro_y,
   output logic signed [31:0] tilt_angle
);
   import ctf_pkg::*;

   // x,y up to 2^15*2^14*~1.65*sqrt2 < 2^31; 34 bits safe
   logic signed [33:0] x_ff, y_ff;
   logic signed [24:0] z_ff;
   logic zero_ff;
   logic signed [15:0] gy_ff;
   logic signed [32:0] rate_ff;
   logic signed [57:0] prod_ff;
   logic signed [33:0] sum_ff;
   logic signed [26:0] acc_ff;
   logic signed [31:0] fused_ff;

   logic signed [33:0] xs, ys, dx, dy;
   logic signed [24:0] zl;
   logic signed [33:0] x_in, y_in;
   logic signed [24:0] z_in;
   logic signed [33:0] delta;
   logic signed [52:0] mix_a, mix_b;
   logic signed [53:0] mix;
   logic signed [37:0] mixs;
   logic signed [31:0] sat;

   // quadrant pre-rotation of the loaded vector
   always_comb begin
      xs = 34'(accel_z) <<< 14;
      ys = 34'(accel_x) <<< 14;
      x_in = xs; y_in = ys; z_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x_in = ys; y_in = -xs; z_in = 25'sd5898240;
         end else begin
            x_in = -ys; y_in = xs; z_in = -25'sd5898240;
         end
      end
   end

   assign dx = y_ff >>> ctrl.step;
   assign dy = x_ff >>> ctrl.step;
   assign zl = 25'(atan_entry(ctrl.step));

   // blend terms
   assign mix_a = $signed({1'b0, regs.blend_weight}) * sum_ff;
   assign mix_b = $signed(18'd65536 - {2'b0, regs.blend_weight}) * acc_ff;
   assign mix = 54'(mix_a) + 54'(mix_b) + 54'sd32768;
   assign mixs = 38'(mix >>> 16);
   assign sat = (mixs > 38'sd2147483647) ? 32'sh7fffffff :
                (mixs < -38'sd2147483648) ? 32'sh80000000 : 32'(mixs);
   assign delta = 34'((prod_ff + 58'sd8388608) >>> 24);
   assign tilt_angle = fused_ff;

   always_ff @(posedge clock) begin
      if (reset) fused_ff <= '0;
      else if (ctrl.cmd == CMD_MIX) fused_ff <= sat;
   end

   // shared cordic and arithmetic steps
   always_ff @(posedge clock) begin
      unique case (ctrl.cmd)
         CMD_LOAD: begin
            x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
            zero_ff <= (accel_x == 0) && (accel_z == 0);
            gy_ff <= gyro_y;
         end
         CMD_ITER: begin
            if (y_ff >= 0) begin
               x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + zl;
            end else begin
               x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - zl;
            end
         end
         CMD_MUL1: begin
            rate_ff <= 33'(gy_ff * $signed({1'b0, regs.gyro_gain})) - 33'(regs.gyro_offset);
            acc_ff <= (zero_ff ? 27'sd0 : -27'(z_ff)) - 27'(regs.angle_offset);
         end
         CMD_MUL2: prod_ff <= rate_ff * $signed({1'b0, regs.time_step});
         CMD_SUM: sum_ff <= 34'(fused_ff) + delta;
         default: ;
      endcase
   end
endmodule

>>> src/complementary_tilt_filter.sv
// Complementary tilt filter: each item (accel_x, accel_z, gyro_y) yields one fused tilt
// angle in signed Q15.16 degrees. An item passes through these steps from acceptance to result
// (a load, 16 CORDIC iterations on one shared shift-add unit, rate multiply, dt multiply,
// integration sum, blend); a new item is accepted in the cycle after the previous result
// has been taken, so no new item enters while one is still in flight.
module complementary_tilt_filter (
   input logic clock,
   input logic reset,
   ctf_req_if.sink req,
   ctf_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import ctf_pkg::*;

   regs_type regs;
   ctrl_type ctrl;

   ctf_regs u_regs (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .regs
   );

   ctf_ctrl u_ctrl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .ctrl
   );

   ctf_datapath u_dp (
      .clock, .reset, .ctrl, .regs, .accel_x(req.accel_x), .accel_z(req.accel_z),
      .gyro_y(req.gyro_y), .tilt_angle(rsp.tilt_angle)
   );
endmodule

>>> sim/tb_pkg.sv
`timescale 1ns / 1ps
package tb_pkg;
   import ctf_pkg::*;

   // cordic atan2 in Q16 degrees
   function automatic longint tilt_atan2(input longint yin, input longint xin);
      longint x, y, z, t, dx, dy;
      x = xin * 16384;
      y = yin * 16384;
      z = 0;
      if (xin == 0 && yin == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(i[StepBits-1:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(i[StepBits-1:0]));
         end
      end
      return z;
   endfunction

   class tilt_scoreboard;
      regs_type regs;
      logic signed [31:0] fused;
      logic signed [31:0] pending_angles[$];
      int errors;

      function new();
         regs.gyro_gain = 16'd500;
         regs.gyro_offset = '0;
         regs.angle_offset = '0;
         regs.time_step = 24'd83886;
         regs.blend_weight = 16'd64881;
         fused = 0;
         errors = 0;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [31:0] v);
         case (idx)
            RegGyroGain: regs.gyro_gain = v[15:0];
            RegGyroOffset: regs.gyro_offset = v[24:0];
            RegAngleOffset: regs.angle_offset = v[24:0];
            RegTimeStep: regs.time_step = v[23:0];
            RegBlendWeight: regs.blend_weight = v[15:0];
            default: ;
         endcase
      endfunction

      // fold one sample into the fused angle
      function void note_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                                input logic signed [15:0] gy);
         longint acc, rate, delta, total, a, mix;
         acc = -tilt_atan2(longint'(ax), longint'(az)) - longint'(regs.angle_offset);
         rate = longint'(gy) * longint'({1'b0, regs.gyro_gain}) - longint'(regs.gyro_offset);
         delta = (rate * longint'({1'b0, regs.time_step}) + (longint'(1) << 23)) >>> 24;
         total = longint'(fused) + delta;
         a = longint'({1'b0, regs.blend_weight});
         mix = (a * total + (65536 - a) * acc + 32768) >>> 16;
         if (mix > 64'sd2147483647) mix = 64'sd2147483647;
         if (mix < -64'sd2147483648) mix = -64'sd2147483648;
         fused = mix[31:0];
         pending_angles.push_back(fused);
      endfunction

      function void check_angle(input logic signed [31:0] got);
         logic signed [31:0] want;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected tilt_angle %0d", $time, got);
            errors++;
            return;
         end
         want = pending_angles.pop_front();
         if (want !== got) begin
            $display("%0t: tilt_angle mismatch expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass
endpackage

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import ctf_pkg::*;
   import tb_pkg::*;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   int send_idle, recv_stall;
   bit hold_rsp;
   bit hold_start;
   int idle_cycles;
   bit done;

   ctf_req_if req();
   ctf_rsp_if rsp();
   tilt_scoreboard sb;

   complementary_tilt_filter uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1;
      req.valid = 0; req.accel_x = 0; req.accel_z = 0; req.gyro_y = 0;
      rsp.ready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle = 0; recv_stall = 0; hold_rsp = 0; hold_start = 0; done = 0;
   end

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      int cnt;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start <= 0;
            hold_rsp <= 1;
            cnt = 0;
         end else if (hold_rsp) begin
            cnt++;
            if (cnt >= 300) hold_rsp <= 0;
         end
         rsp.ready <= !reset && !hold_rsp && !hold_start
                      && ($urandom_range(99) >= recv_stall);
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_angle(rsp.tilt_angle);
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || done)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("complementary_tilt_filter test failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, v);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_sample(input logic [15:0] ax, input logic [15:0] az,
                              input logic [15:0] gy);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.accel_x <= ax; req.accel_z <= az; req.gyro_y <= gy;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_sample(ax, az, gy);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (sb.pending_angles.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic random_sample();
      logic [15:0] ax, az, gy;
      ax = 16'($urandom); az = 16'($urandom); gy = 16'($urandom);
      case ($urandom_range(3))
         0: begin ax = 16'($urandom_range(200) - 100); end
         1: begin ax = 16'd0; end
         2: begin gy = 16'($urandom_range(2000) - 1000); end
         default: ;
      endcase
      send_sample(ax, az, gy);
   endtask

   initial begin
      logic [15:0] ext[4];
      ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, zero vector, negative z on axis
      send_sample(16'd0, 16'd0, 16'd0);
      send_sample(16'd0, 16'hc000, 16'd0);
      send_sample(16'd0, 16'h8000, 16'h7fff);
      foreach (ext[i]) foreach (ext[j]) send_sample(ext[i], ext[j], ext[(i + j) % 4]);
      drain();

      // register extremes, unknown index ignored
      csr_write(RegGyroGain, 32'hffffffff);
      csr_write(RegGyroOffset, 32'h01000000);
      csr_write(RegAngleOffset, -32'sd11796480);
      csr_write(RegTimeStep, 32'hffffff);
      csr_write(RegBlendWeight, 32'hffff);
      csr_write(3'd5, 32'h12345678);
      repeat (4) send_sample(16'h7fff, 16'd0, 16'h7fff);
      repeat (4) send_sample(16'h8000, 16'd0, 16'h8000);
      drain();

      // random phases with different settings and idling
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 64; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 64; end
            3: begin send_idle = 25; recv_stall = 25; end
            4: begin send_idle = 0; recv_stall = 0; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         csr_write(RegGyroGain, ph == 4 ? 0 : $urandom);
         csr_write(RegGyroOffset, ph == 4 ? 32'h00ffffff : $urandom);
         csr_write(RegAngleOffset, ph == 4 ? 32'sd11796480
                   : $urandom_range(23592960) - 11796480);
         csr_write(RegTimeStep, ph == 4 ? 0 : $urandom);
         csr_write(RegBlendWeight, ph == 4 ? 0 : (ph == 0 ? 64881 : $urandom));
         if (ph == 3) hold_start <= 1;
         repeat (250) random_sample();
         drain();
      end

      done = 1;
      if (sb.errors == 0 && sb.pending_angles.size() == 0)
         $display("complementary_tilt_filter test passed");
      else
         $display("complementary_tilt_filter test failed");
      $finish;
   end
endmodule
